// File: design/dwc_pkg.sv
// Package for the decimating waveform capture block.
// Holds the fixed field widths, Q2.14 constants and register map codes.
// No dependencies; imported by the channel interfaces and the top level.
package dwc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned SampleW = 16;
  localparam int unsigned ColumnW = 7;
  localparam int unsigned RowW    = 6;
  localparam int unsigned GenW    = 32;
  localparam int unsigned FactorW = 8;

  // Q2.14 fixed point: 1.0 and the rounding half of the final >> 15
  localparam int unsigned FracW  = 15;
  localparam logic signed [SampleW-1:0] QOne = 16'sd16384;
  localparam logic signed [SampleW-1:0] QNegOne = -16'sd16384;
  localparam logic [FracW-1:0] RoundHalf = 15'd16384;

  // Configuration register map
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [FactorW-1:0] DecimFactorReset = 8'd12;

  typedef enum logic {
    REG_DECIM_FACTOR = 1'b0
  } reg_idx_e;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_READ    = 1'b1
  } item_mode_e;

  // Read transaction state carried alongside the memory read
  typedef struct packed {
    logic            valid;
    logic            avail;
    logic [GenW-1:0] generation;
  } rd_stage_t;

endpackage

// File: design/dwc_in_if.sv
// Input channel of the waveform capture block: valid/ready plus one item.
// Depends on dwc_pkg for the field widths.
interface dwc_in_if
  import dwc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [SampleW-1:0] sample;
  logic [ColumnW-1:0]        column;

  modport source (output valid, output mode, output sample, output column, input ready);
  modport sink   (input valid, input mode, input sample, input column, output ready);
endinterface

// File: design/dwc_out_if.sv
// Output channel of the waveform capture block: valid/ready plus one result.
// Depends on dwc_pkg for the field widths.
interface dwc_out_if
  import dwc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row;
  logic            frame_available;
  logic [GenW-1:0] generation;

  modport source (output valid, output row, output frame_available, output generation,
                  input ready);
  modport sink   (input valid, input row, input frame_available, input generation,
                  output ready);
endinterface

// File: design/decimating_waveform_capture_top.sv
// Decimating waveform capture: keeps one audio sample in decimation_factor, maps it to a
// display row and fills the back bank of a two-bank line store; a full line swaps banks
// and bumps the 32-bit generation. The block takes one item per clock cycle, capture or
// read alike, while the output is not stalled; a read passes the read stage, which
// registers the store data, then the output register. A capture is written to the
// store in the cycle it is accepted, so a read right behind it already sees the new frame.
// The line store comes out of reset with unknown contents, but a read before any frame
// returns row zero, so no clearing pass is needed. Depends on dwc_pkg and the interfaces.
module decimating_waveform_capture_top
  import dwc_pkg::*;
#(
  parameter int unsigned LINE_WIDTH     = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  // item channels
  dwc_in_if.sink            in_i,
  dwc_out_if.source         out_o
);

  localparam int unsigned IdxW   = $clog2(LINE_WIDTH);
  localparam int unsigned AddrW  = IdxW + 1;
  localparam int unsigned Depth  = 2 ** AddrW;
  localparam int unsigned ColExtW = 9;
  localparam int unsigned HgtW   = 8;
  localparam int unsigned ProdW  = SampleW + HgtW + 1;
  localparam logic [HgtW-1:0]    HeightM1  = HgtW'(DISPLAY_HEIGHT - 1);
  localparam logic [IdxW-1:0]    LastIdx   = IdxW'(LINE_WIDTH - 1);
  localparam logic [ColExtW-1:0] LineLimit = ColExtW'(LINE_WIDTH);
  localparam logic [ColExtW-1:0] LastCol   = ColExtW'(LINE_WIDTH - 1);

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [FactorW-1:0] factor_q;
  logic               cfg_wr;
  logic               sel_factor;

  assign pready     = 1'b1;
  assign sel_factor = (reg_idx_e'(paddr[2]) == REG_DECIM_FACTOR);
  assign cfg_wr     = psel & penable & pwrite & sel_factor;
  assign prdata     = sel_factor ? PdataW'(factor_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= DecimFactorReset;
    end else if (cfg_wr) begin
      factor_q <= pwdata[FactorW-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------
  rd_stage_t s1_q;
  logic      out_valid_q;
  logic      out_free;
  logic      s1_free;
  logic      in_fire;
  logic      cap_fire;
  logic      rd_fire;

  assign out_free = ~out_valid_q | out_o.ready;
  assign s1_free  = ~s1_q.valid | out_free;
  assign in_i.ready = s1_free;
  assign in_fire  = in_i.valid & s1_free;
  assign cap_fire = in_fire & (item_mode_e'(in_i.mode) == MODE_CAPTURE);
  assign rd_fire  = in_fire & (item_mode_e'(in_i.mode) == MODE_READ);

  // ---------------------------------------------------------------
  // Sample to row mapping: clamp to [-1, 1], scale, round half up
  // ---------------------------------------------------------------
  logic signed [SampleW-1:0] s_clamp;
  logic signed [SampleW:0]   span_s;
  logic [SampleW-1:0]        span;
  logic [ProdW-1:0]          prod;
  logic [RowW-1:0]           new_row;

  always_comb begin
    if (in_i.sample > QOne) begin
      s_clamp = QOne;
    end else if (in_i.sample < QNegOne) begin
      s_clamp = QNegOne;
    end else begin
      s_clamp = in_i.sample;
    end
    span_s  = (SampleW + 1)'(QOne) - (SampleW + 1)'(s_clamp);
    span    = span_s[SampleW-1:0];
    prod    = ProdW'(span) * ProdW'(HeightM1) + ProdW'(RoundHalf);
    new_row = prod[FracW +: RowW];
  end

  // ---------------------------------------------------------------
  // Decimation, fill index and generation
  // ---------------------------------------------------------------
  logic [FactorW-1:0] decim_q, decim_d;
  logic [IdxW-1:0]    fill_q, fill_d;
  logic [GenW-1:0]    gen_q, gen_d;
  logic [FactorW-1:0] decim_inc;
  logic               keep;

  always_comb begin
    decim_inc = decim_q + 1'b1;
    keep      = cap_fire & (decim_inc >= factor_q);
    decim_d   = decim_q;
    fill_d    = fill_q;
    gen_d     = gen_q;
    if (cap_fire) begin
      decim_d = keep ? '0 : decim_inc;
    end
    // advance the fill index; swap banks when the line is full
    if (keep) begin
      if (fill_q == LastIdx) begin
        fill_d = '0;
        gen_d  = gen_q + 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= '0;
      fill_q  <= '0;
      gen_q   <= '0;
    end else begin
      decim_q <= decim_d;
      fill_q  <= fill_d;
      gen_q   <= gen_d;
    end
  end

  // ---------------------------------------------------------------
  // Line store: back bank written, published bank read
  // ---------------------------------------------------------------
  logic [RowW-1:0]    line_mem [Depth];
  logic [RowW-1:0]    rd_data_q;
  logic [AddrW-1:0]   wr_addr;
  logic [AddrW-1:0]   rd_addr;
  logic [ColExtW-1:0] col_ext;
  logic [ColExtW-1:0] col_sat;

  assign col_ext = ColExtW'(in_i.column);
  assign col_sat = (col_ext >= LineLimit) ? LastCol : col_ext;
  assign wr_addr = {~gen_q[0], fill_q};
  assign rd_addr = {gen_q[0], col_sat[IdxW-1:0]};

  always_ff @(posedge clk_i) begin
    if (keep) begin
      line_mem[wr_addr] <= new_row;
    end
  end

  // hold read data while the read stage is stalled
  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // Read stage and output register
  // ---------------------------------------------------------------
  logic [RowW-1:0] out_row_q;
  logic            out_avail_q;
  logic [GenW-1:0] out_gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      if (s1_free) begin
        s1_q.valid <= rd_fire;
      end
      if (rd_fire) begin
        s1_q.avail      <= (gen_q != '0);
        s1_q.generation <= gen_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_q.valid) begin
      out_row_q   <= s1_q.avail ? rd_data_q : '0;
      out_avail_q <= s1_q.avail;
      out_gen_q   <= s1_q.generation;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.row             = out_row_q;
  assign out_o.frame_available = out_avail_q;
  assign out_o.generation      = out_gen_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for decimating_waveform_capture_top: drives capture and column reads, predicts
// each readout from the script or a local trace model and checks it. Depends on dwc_pkg and the interfaces.
module tb;
  import dwc_pkg::*;

  localparam int LineLen    = 128;
  localparam int Height     = 64;
  localparam int IdlePct    = 38;
  localparam int SettleCyc  = 4;
  localparam int StallLimit = 5000;
  localparam int AnyFactor  = -1;
  localparam int NumPhases  = 12;
  localparam int ScriptLen  = 21;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic            avail;
    logic [GenW-1:0] gen;
  } column_readout_t;

  typedef struct packed {
    item_mode_e         mode;
    logic [SampleW-1:0] sample;
    logic [ColumnW-1:0] column;
    logic               typed;
    column_readout_t    readout;
  } script_row_t;

  localparam column_readout_t NoFrame = '{row: '0, avail: 1'b0, gen: '0};

  // Directed opening: reads before any frame, clamp and rounding extremes of the sample,
  // one kept sample at the reset factor, and a count left above the next factor.
  localparam script_row_t Script [ScriptLen] = '{
    '{MODE_READ,    16'h0000, 7'd0,   1'b1, NoFrame},
    '{MODE_READ,    16'hFFFF, 7'd127, 1'b1, NoFrame},
    '{MODE_CAPTURE, 16'h7FFF, 7'd0,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h8000, 7'd127, 1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h4000, 7'd1,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hC000, 7'd2,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h4001, 7'd4,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hBFFF, 7'd8,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h0000, 7'd16,  1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h0001, 7'd32,  1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hFFFF, 7'd64,  1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h3FFF, 7'd85,  1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hC001, 7'd42,  1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h7FFF, 7'd0,   1'b0, NoFrame},
    '{MODE_READ,    16'h5555, 7'd64,  1'b1, NoFrame},
    '{MODE_CAPTURE, 16'h0064, 7'd0,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hFF9C, 7'd0,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'h2000, 7'd0,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hE000, 7'd0,   1'b0, NoFrame},
    '{MODE_CAPTURE, 16'hAAAA, 7'd0,   1'b0, NoFrame},
    '{MODE_READ,    16'h0000, 7'd127, 1'b1, NoFrame}
  };

  // Factor and length of each random phase; the first lowers the factor below the count
  localparam int PhaseFactor [NumPhases] = '{3, 0, 1, 255, 1, 2, AnyFactor, 1, 4, AnyFactor,
                                             1, 12};
  localparam int PhaseItems [NumPhases] = '{120, 120, 120, 450, 120, 120, 120, 120, 120, 120,
                                            120, 120};
  localparam int SteadyPhase = 4;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  dwc_in_if  in_ch ();
  dwc_out_if out_ch ();

  decimating_waveform_capture_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // Trace model: decimation, double-buffered line and published generation
  logic [FactorW-1:0] trace_factor;
  logic [FactorW-1:0] trace_count;
  int unsigned        trace_fill;
  logic [GenW-1:0]    trace_gen;
  logic [RowW-1:0]    trace_line [2][LineLen];

  column_readout_t pending_readouts [$];
  int              failures = 0;
  bit              steady = 1'b0;
  int              stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [RowW-1:0] sample_to_row(logic signed [SampleW-1:0] s);
    int          level;
    int unsigned span;
    level = s;
    if (level > int'(QOne)) level = int'(QOne);
    if (level < int'(QNegOne)) level = int'(QNegOne);
    span = int'(QOne) - level;
    return RowW'((span * (Height - 1) + int'(RoundHalf)) >> FracW);
  endfunction

  function automatic void capture_trace(logic [SampleW-1:0] s);
    logic back;
    trace_count = trace_count + 1'b1;
    if (trace_count < trace_factor) return;
    trace_count = '0;
    back = ~trace_gen[0];
    trace_line[back][trace_fill] = sample_to_row(s);
    trace_fill++;
    if (trace_fill >= LineLen) begin
      trace_gen  = trace_gen + 1;
      trace_fill = 0;
    end
  endfunction

  function automatic column_readout_t lookup_column(logic [ColumnW-1:0] column);
    column_readout_t res;
    int              col;
    col = column;
    if (col >= LineLen) col = LineLen - 1;
    res = NoFrame;
    res.gen = trace_gen;
    if (trace_gen != '0) begin
      res.avail = 1'b1;
      res.row   = trace_line[trace_gen[0]][col];
    end
    return res;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    logic [SampleW-1:0] edges [7];
    edges = '{QOne, QNegOne, 16'h4001, 16'hBFFF, 16'h7FFF, 16'h8000, 16'h0000};
    case ($urandom_range(0, 3))
      0: return SampleW'($urandom);
      1, 2: return SampleW'(int'($urandom_range(0, 32768)) - 16384);
      default: return edges[$urandom_range(0, 6)];
    endcase
  endfunction

  // Send one item, hold it until accepted, then advance the trace model or queue a prediction
  task automatic deliver(item_mode_e mode, logic [SampleW-1:0] sample,
                         logic [ColumnW-1:0] column, logic typed, column_readout_t readout);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.sample <= sample;
    in_ch.column <= column;
    do @(posedge clk_i); while (!in_ch.ready);
    if (mode == MODE_CAPTURE) begin
      capture_trace(sample);
    end else begin
      pending_readouts.push_back(typed ? readout : lookup_column(column));
    end
  endtask

  // Stop sending, wait for every readout, then let the pipeline settle
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Write the decimation factor, then read it back
  task automatic program_factor(logic [FactorW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(int'(REG_DECIM_FACTOR) * 4);
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    trace_factor = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[FactorW-1:0] !== value) begin
      $error("decimation_factor: expected %0d, got %0d", value, prdata[FactorW-1:0]);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stall the result channel at random and check each readout against the oldest prediction
  always @(posedge clk_i) begin
    column_readout_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_readouts.size() == 0) begin
          $error("readout with no column read waiting: row %0d", out_ch.row);
          failures++;
        end else begin
          want = pending_readouts.pop_front();
          if (out_ch.row !== want.row) begin
            $error("row: expected %0d, got %0d", want.row, out_ch.row);
            failures++;
          end
          if (out_ch.frame_available !== want.avail) begin
            $error("frame_available: expected %0d, got %0d", want.avail,
                   out_ch.frame_available);
            failures++;
          end
          if (out_ch.generation !== want.gen) begin
            $error("generation: expected %0d, got %0d", want.gen, out_ch.generation);
            failures++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Drop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int factor;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_CAPTURE;
    in_ch.sample = '0;
    in_ch.column = '0;
    trace_factor = DecimFactorReset;
    trace_count  = '0;
    trace_fill   = 0;
    trace_gen    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Script[i]) begin
      deliver(Script[i].mode, Script[i].sample, Script[i].column, Script[i].typed,
              Script[i].readout);
    end

    // Random phases, each at its own factor
    for (int p = 0; p < NumPhases; p++) begin
      drain_and_settle();
      factor = (PhaseFactor[p] == AnyFactor) ? $urandom_range(1, 8) : PhaseFactor[p];
      program_factor(FactorW'(factor));
      steady = (p == SteadyPhase);
      for (int n = 0; n < PhaseItems[p]; n++) begin
        if (!steady && $urandom_range(0, 199) == 0) drain_and_settle();
        deliver(item_mode_e'(($urandom_range(0, 99) < 70) ? MODE_CAPTURE : MODE_READ),
                pick_sample(),
                ($urandom_range(0, 3) == 0) ? ColumnW'($urandom_range(0, 1) * (LineLen - 1))
                                            : ColumnW'($urandom),
                1'b0, NoFrame);
      end
      steady = 1'b0;
    end

    drain_and_settle();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
